// File: src/tbp_pkg.sv
// Shared definitions for the tournament branch predictor.
// Default table geometry, the pc width, operation codes and the counter-table command struct.
// No dependencies.
package tbp_pkg;

   // default geometry, handed to the top-level parameters
   localparam int PC_IDX_BITS_DEF      = 10;
   localparam int LOCAL_HIST_BITS_DEF  = 10;
   localparam int GLOBAL_HIST_BITS_DEF = 12;
   localparam int LOCAL_CTR_BITS_DEF   = 3;
   localparam int GLOBAL_CTR_BITS_DEF  = 2;

   // width of the branch address field
   localparam int PC_BITS = 32;

   // request operation codes
   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_TRAIN   = 1'b1;

   // command to one saturating-counter table
   typedef struct packed {
      logic rd_en;   // read the entry at addr
      logic clr_en;  // write the reset value at addr
      logic upd_en;  // write back the last-read entry moved one step
      logic up;      // direction of that step
   } ctr_cmd_type;

endpackage

// File: src/tbp_ctr_ram.sv
// Saturating-counter table in one synchronous memory with a registered read.
// Updates write the last-read entry back, moved one step up or down.
// Depends on tbp_pkg (ctr_cmd_type).
module tbp_ctr_ram #(
   parameter int IDX_BITS = tbp_pkg::GLOBAL_HIST_BITS_DEF,
   parameter int CTR_BITS = tbp_pkg::GLOBAL_CTR_BITS_DEF
) (
   input  logic                  clock,
   input  tbp_pkg::ctr_cmd_type  cmd,
   input  logic [IDX_BITS-1:0]   addr,
   output logic                  guess
);

   localparam int DEPTH = 1 << IDX_BITS;
   localparam logic [CTR_BITS-1:0] CTR_WEAK = CTR_BITS'((1 << (CTR_BITS - 1)) - 1);
   localparam logic [CTR_BITS-1:0] CTR_MAX  = '1;
   localparam logic [CTR_BITS-1:0] CTR_ZERO = '0;
   localparam logic [CTR_BITS-1:0] CTR_ONE  = CTR_BITS'(1);

   logic [CTR_BITS-1:0] mem_ff [DEPTH];
   logic [CTR_BITS-1:0] rd_data_ff;
   logic [IDX_BITS-1:0] addr_ff;
   logic [CTR_BITS-1:0] upd_in;

   // move the held entry one step, saturating at both ends
   always_comb begin
      if (cmd.up) begin
         upd_in = (rd_data_ff == CTR_MAX) ? CTR_MAX : rd_data_ff + CTR_ONE;
      end else begin
         upd_in = (rd_data_ff == CTR_ZERO) ? CTR_ZERO : rd_data_ff - CTR_ONE;
      end
   end

   // write port: clearing pass or read-modify-write of the held entry
   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         mem_ff[addr] <= CTR_WEAK;
      end else if (cmd.upd_en) begin
         mem_ff[addr_ff] <= upd_in;
      end
   end

   // read port: hold data and address until the next read
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[addr];
         addr_ff    <= addr;
      end
   end

   // taken, or prefer global, in the upper half
   assign guess = rd_data_ff[CTR_BITS-1];

endmodule

// File: src/tournament_branch_predictor.sv
// Tournament branch predictor: local history table, local, global and chooser
// counter tables, global history register. Depends on tbp_pkg, tbp_ctr_ram.
//
//   channel   ports                                        handshake
//   request   req_operation, req_pc, req_taken             start & !busy
//   result    rsp_prediction, rsp_local_guess,             rsp_valid, one cycle
//             rsp_global_guess, rsp_used_global
//
// A request runs as local history read, local counter read, then result and
// write-back; the result strobe comes in the cycle after, when busy is already
// low again. The dependent history-then-counter memory read sets these steps.
// After reset a clearing pass writes every table, 2^max(PC_IDX_BITS,
// LOCAL_HIST_BITS, GLOBAL_HIST_BITS) addresses (4096 by default), busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
module tournament_branch_predictor #(
   parameter int PC_IDX_BITS      = tbp_pkg::PC_IDX_BITS_DEF,
   parameter int LOCAL_HIST_BITS  = tbp_pkg::LOCAL_HIST_BITS_DEF,
   parameter int GLOBAL_HIST_BITS = tbp_pkg::GLOBAL_HIST_BITS_DEF,
   parameter int LOCAL_CTR_BITS   = tbp_pkg::LOCAL_CTR_BITS_DEF,
   parameter int GLOBAL_CTR_BITS  = tbp_pkg::GLOBAL_CTR_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_operation,
   input  logic [tbp_pkg::PC_BITS-1:0] req_pc,
   input  logic                        req_taken,
   output logic                        rsp_valid,
   output logic                        rsp_prediction,
   output logic                        rsp_local_guess,
   output logic                        rsp_global_guess,
   output logic                        rsp_used_global
);

   localparam int LG_MAX   = (PC_IDX_BITS > LOCAL_HIST_BITS) ? PC_IDX_BITS : LOCAL_HIST_BITS;
   localparam int CLR_BITS = (LG_MAX > GLOBAL_HIST_BITS) ? LG_MAX : GLOBAL_HIST_BITS;
   localparam int LHT_DEPTH = 1 << PC_IDX_BITS;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_HIST,
      S_CTR
   } state_type;

   state_type                    state_ff, state_in;
   logic [CLR_BITS-1:0]          clr_cnt_ff;
   logic [GLOBAL_HIST_BITS-1:0]  ghist_ff, ghist_in;
   logic [GLOBAL_HIST_BITS:0]    ghist_shift;
   logic                         rsp_valid_ff;
   logic                         pred_ff, lg_ff, gg_ff, ug_ff;

   logic                         op_ff, taken_ff;
   logic [PC_IDX_BITS-1:0]       pc_idx_ff;

   logic [LOCAL_HIST_BITS-1:0]   lht_mem_ff [LHT_DEPTH];
   logic [LOCAL_HIST_BITS-1:0]   lhist_ff, lhist_in;
   logic [LOCAL_HIST_BITS:0]     lhist_shift;

   logic                         accept, clearing, train_wb;
   logic                         lct_guess, gct_guess, cht_guess;
   tbp_pkg::ctr_cmd_type         lct_cmd, gct_cmd, cht_cmd;
   logic [LOCAL_HIST_BITS-1:0]   lct_addr;
   logic [GLOBAL_HIST_BITS-1:0]  g_addr;

   assign accept   = start && (state_ff == S_IDLE);
   assign clearing = (state_ff == S_CLEAR);
   assign train_wb = (state_ff == S_CTR) && (op_ff == tbp_pkg::OP_TRAIN);
   assign busy     = (state_ff != S_IDLE);

   // shift the outcome into both histories
   assign lhist_shift = {lhist_ff, taken_ff};
   assign lhist_in    = lhist_shift[LOCAL_HIST_BITS-1:0];
   assign ghist_shift = {ghist_ff, taken_ff};
   assign ghist_in    = ghist_shift[GLOBAL_HIST_BITS-1:0];

   // advance the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (&clr_cnt_ff) state_in = S_IDLE;
         S_IDLE:  if (start) state_in = S_HIST;
         S_HIST:  state_in = S_CTR;
         S_CTR:   state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   // hold state, clearing counter, global history and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         ghist_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_CTR);
         if (clearing) begin
            clr_cnt_ff <= clr_cnt_ff + CLR_BITS'(1);
         end
         if (train_wb) begin
            ghist_ff <= ghist_in;
         end
      end
   end

   // capture the request and, at the last step, the result fields
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_operation;
         taken_ff  <= req_taken;
         pc_idx_ff <= req_pc[PC_IDX_BITS-1:0];
      end
      if (state_ff == S_CTR) begin
         lg_ff   <= lct_guess;
         gg_ff   <= gct_guess;
         ug_ff   <= cht_guess;
         pred_ff <= cht_guess ? gct_guess : lct_guess;
      end
   end

   // local history table: clear, write back the shifted history, read on accept
   always_ff @(posedge clock) begin
      if (clearing) begin
         lht_mem_ff[clr_cnt_ff[PC_IDX_BITS-1:0]] <= '0;
      end else if (train_wb) begin
         lht_mem_ff[pc_idx_ff] <= lhist_in;
      end
      if (accept) begin
         lhist_ff <= lht_mem_ff[req_pc[PC_IDX_BITS-1:0]];
      end
   end

   // counter table commands
   always_comb begin
      lct_cmd.rd_en  = (state_ff == S_HIST);
      lct_cmd.clr_en = clearing;
      lct_cmd.upd_en = train_wb;
      lct_cmd.up     = taken_ff;

      gct_cmd.rd_en  = accept;
      gct_cmd.clr_en = clearing;
      gct_cmd.upd_en = train_wb;
      gct_cmd.up     = taken_ff;

      // chooser moves only when the two guesses disagree
      cht_cmd.rd_en  = accept;
      cht_cmd.clr_en = clearing;
      cht_cmd.upd_en = train_wb && (lct_guess != gct_guess);
      cht_cmd.up     = (gct_guess == taken_ff);
   end

   assign lct_addr = clearing ? clr_cnt_ff[LOCAL_HIST_BITS-1:0] : lhist_ff;
   assign g_addr   = clearing ? clr_cnt_ff[GLOBAL_HIST_BITS-1:0] : ghist_ff;

   tbp_ctr_ram #(
      .IDX_BITS (LOCAL_HIST_BITS),
      .CTR_BITS (LOCAL_CTR_BITS)
   ) u_lct (
      .clock (clock),
      .cmd   (lct_cmd),
      .addr  (lct_addr),
      .guess (lct_guess)
   );

   tbp_ctr_ram #(
      .IDX_BITS (GLOBAL_HIST_BITS),
      .CTR_BITS (GLOBAL_CTR_BITS)
   ) u_gct (
      .clock (clock),
      .cmd   (gct_cmd),
      .addr  (g_addr),
      .guess (gct_guess)
   );

   tbp_ctr_ram #(
      .IDX_BITS (GLOBAL_HIST_BITS),
      .CTR_BITS (GLOBAL_CTR_BITS)
   ) u_cht (
      .clock (clock),
      .cmd   (cht_cmd),
      .addr  (g_addr),
      .guess (cht_guess)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_prediction   = pred_ff;
   assign rsp_local_guess  = lg_ff;
   assign rsp_global_guess = gg_ff;
   assign rsp_used_global  = ug_ff;

`ifndef SYNTH
   // every accepted request yields its result once its history and counter steps are done
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("result strobe missing after accepted request");

   // a result appears only after the write-back step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_CTR))
      else $error("result strobe without a finished request");

   // the chosen guess follows the chooser
   a_pred_choice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_prediction == (rsp_used_global ? rsp_global_guess
                                                        : rsp_local_guess)))
      else $error("prediction does not match chooser selection");

   // global history moves only on a training write-back
   a_ghist_train: assert property (@(posedge clock) disable iff (reset)
      !$stable(ghist_ff) |-> $past(reset || train_wb))
      else $error("global history changed without training");

   // no request taken during the clearing pass
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      clearing |-> busy && !accept)
      else $error("request accepted during clearing pass");
`endif

endmodule
